### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the video port blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define VDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds during reset
`define VDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/vdp_pkg.sv
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared types, codes and constants of the video processor port block
// ----------------------------------------------------------------------------
package vdp_pkg;

    // video memory geometry
    localparam int VramDepth = 16384;
    localparam int VramAw    = $clog2(VramDepth);
    localparam int AddrW     = 14;

    // processor actions
    localparam logic [2:0] ACT_DATA_WRITE = 3'd0;
    localparam logic [2:0] ACT_DATA_READ  = 3'd1;
    localparam logic [2:0] ACT_CTRL_WRITE = 3'd2;
    localparam logic [2:0] ACT_STAT_READ  = 3'd3;
    localparam logic [2:0] ACT_LINE_TICK  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_VRAM_SIZE = 2'd0;
    localparam logic [1:0] CFG_FAMILY    = 2'd1;
    localparam logic [1:0] CFG_REVISION  = 2'd2;
    localparam logic [1:0] CFG_PAL       = 2'd3;

    // control register numbers
    localparam logic [2:0] CR_MODE0   = 3'd0;
    localparam logic [2:0] CR_MODE1   = 3'd1;
    localparam logic [2:0] CR_NAME    = 3'd2;
    localparam logic [2:0] CR_COLOUR  = 3'd3;
    localparam logic [2:0] CR_PATTERN = 3'd4;
    localparam logic [2:0] CR_SATTR   = 3'd5;
    localparam logic [2:0] CR_SPAT    = 3'd6;

    // writable bits of each control register
    localparam logic [7:0] RegWriteMask [8] = '{
        8'h03, 8'hfb, 8'h0f, 8'hff, 8'h07, 8'h7f, 8'h07, 8'hff
    };

    // frame timing
    localparam logic [9:0] TopBorderNtsc = 10'd40;
    localparam logic [9:0] TopBorderPal  = 10'd64;
    localparam logic [9:0] LinesNtsc     = 10'd262;
    localparam logic [9:0] LinesPal      = 10'd313;
    localparam logic [9:0] ActiveLines   = 10'd193;

    // status byte
    localparam logic [4:0] FifthSpriteIdle = 5'd31;
    localparam int         StatVblankBit   = 7;
    localparam int         R1IntEnableBit  = 5;

    // memory request from the port logic
    typedef struct packed {
        logic              re;
        logic              we;
        logic [VramAw-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // table bases, masks and mode
    typedef struct packed {
        logic [2:0]       mode;
        logic [AddrW-1:0] name_base;
        logic [AddrW-1:0] colour_base;
        logic [AddrW-1:0] pattern_base;
        logic [AddrW-1:0] sattr_base;
        logic [AddrW-1:0] spat_base;
        logic [AddrW-1:0] colour_mask;
        logic [AddrW-1:0] pattern_mask;
    } tables_t;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       int_line;
        tables_t    tbl;
    } result_t;

    // address mask for the selected memory size
    function automatic logic [AddrW-1:0] size_mask(input logic [1:0] sel);
        logic [AddrW:0] sz;
        case (sel)
            2'd0:    sz = 15'd4096;
            2'd1:    sz = 15'd8192;
            default: sz = 15'd16384;
        endcase
        if (sz > 15'(VramDepth))
            sz = 15'(VramDepth);
        return AddrW'(sz - 15'd1);
    endfunction

endpackage

### src/vdp_vram.sv
// ----------------------------------------------------------------------------
// vdp_vram
// Single port video memory with a clearing sweep after reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdp_vram (
    input  logic               clk,
    input  logic               rst_n,
    input  vdp_pkg::mem_req_t  req,
    output logic [7:0]         rdata,
    output logic               busy
);
    import vdp_pkg::*;

    logic [7:0]        mem [VramDepth];
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [VramAw-1:0] clr_addr_reg;
    logic [VramAw-1:0] clr_addr_next;

    // clearing sweep, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == VramAw'(VramDepth - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // storage array, registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= 8'h00;
        else if (req.we)
            mem[req.addr] <= req.wdata;
        if (req.re)
            rdata <= mem[req.addr];
    end

    assign busy = clr_busy_reg;

    // no port access may overlap the sweep
    `VDP_ASSERT(a_no_access_while_clearing, clk, rst_n,
        clr_busy_reg |-> !(req.we || req.re), "memory access during clearing sweep")

endmodule

### src/vdp_regs.sv
// ----------------------------------------------------------------------------
// vdp_regs
// Port state: address latch, read-ahead, control registers, status, timing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdp_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [2:0]                   action,
    input  logic [7:0]                   data,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [1:0]                   cfg_data,
    input  logic [7:0]                   mem_rdata,
    output vdp_pkg::mem_req_t            mem_req,
    output vdp_pkg::result_t             result
);
    import vdp_pkg::*;

    // configuration
    logic [1:0] size_sel_reg;
    logic       family_reg;
    logic       rev_a_reg;
    logic       pal_reg;

    // port state
    logic [7:0]       ctrl_reg [8];
    logic [7:0]       ctrl_next [8];
    logic [7:0]       status_reg, status_next;
    logic [AddrW-1:0] addr_reg, addr_next;
    logic [7:0]       ra_reg, ra_next;
    logic             pend_reg, pend_next;
    logic             int_reg, int_next;
    logic [8:0]       line_reg, line_next;
    tables_t          tbl_reg, tbl_next;
    logic             fetch_reg, fetch_next;

    // working values
    logic [AddrW-1:0] sm;
    logic [7:0]       ra_eff;
    logic [7:0]       rd;
    logic [AddrW-1:0] addr_m;
    logic [AddrW-1:0] addr_hi;
    logic [2:0]       wr_idx;
    logic [7:0]       wr_val;
    logic             bitmap;
    logic [AddrW-1:0] cmask;
    logic [AddrW-1:0] pmask;
    logic [7:0]       pm_low;
    logic [9:0]       line_inc;
    logic [9:0]       top_border;
    logic [9:0]       frame_lines;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_sel_reg <= 2'd2;
            family_reg   <= 1'b0;
            rev_a_reg    <= 1'b1;
            pal_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VRAM_SIZE: size_sel_reg <= cfg_data;
                CFG_FAMILY:    family_reg   <= cfg_data[0];
                CFG_REVISION:  rev_a_reg    <= cfg_data[0];
                CFG_PAL:       pal_reg      <= cfg_data[0];
                default:       size_sel_reg <= size_sel_reg;
            endcase
        end
    end

    // shared terms
    always_comb
    begin
        sm          = size_mask(size_sel_reg);
        ra_eff      = fetch_reg ? mem_rdata : ra_reg;
        addr_m      = addr_reg & sm;
        addr_hi     = {data[5:0], addr_reg[7:0]} & sm;
        wr_idx      = data[2:0];
        wr_val      = addr_hi[7:0] & RegWriteMask[wr_idx];
        top_border  = pal_reg ? TopBorderPal : TopBorderNtsc;
        frame_lines = pal_reg ? LinesPal : LinesNtsc;
        line_inc    = {1'b0, line_reg} + 10'd1;
        for (int i = 0; i < 8; i++)
            ctrl_next[i] = ctrl_reg[i];
        ctrl_next[wr_idx] = wr_val;
        bitmap = ctrl_next[CR_MODE0][1];
        // bitmap-mode index masks from the updated registers
        cmask  = {4'b0000, ctrl_next[CR_COLOUR][6:0], 3'b111};
        pm_low = family_reg ? cmask[7:0] : 8'hff;
        pmask  = {4'b0000, ctrl_next[CR_PATTERN][1:0], pm_low};
    end

    // action decode
    always_comb
    begin
        status_next = status_reg;
        addr_next   = addr_reg;
        ra_next     = ra_eff;
        pend_next   = pend_reg;
        int_next    = int_reg;
        line_next   = line_reg;
        tbl_next    = tbl_reg;
        fetch_next  = 1'b0;
        rd          = 8'h00;
        mem_req     = '0;

        if (accept)
        begin
            case (action)
                ACT_DATA_WRITE:
                begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = addr_m[VramAw-1:0];
                    mem_req.wdata = data;
                    addr_next     = (addr_m + 1'b1) & sm;
                    ra_next       = data;
                    pend_next     = 1'b0;
                end
                ACT_DATA_READ:
                begin
                    rd           = ra_eff;
                    mem_req.re   = 1'b1;
                    mem_req.addr = addr_m[VramAw-1:0];
                    fetch_next   = 1'b1;
                    addr_next    = (addr_m + 1'b1) & sm;
                    pend_next    = 1'b0;
                end
                ACT_CTRL_WRITE:
                begin
                    if (!pend_reg)
                    begin
                        addr_next = {addr_reg[AddrW-1:8], data} & sm;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        addr_next = addr_hi;
                        if (data[7])
                        begin
                            // control register write
                            case (wr_idx)
                                CR_MODE0:
                                begin
                                    if (bitmap)
                                    begin
                                        tbl_next.colour_base =
                                            {ctrl_next[CR_COLOUR][7], 13'b0} & sm;
                                        tbl_next.pattern_base =
                                            {ctrl_next[CR_PATTERN][2], 13'b0} & sm;
                                        tbl_next.colour_mask  = cmask;
                                        tbl_next.pattern_mask = pmask;
                                    end
                                    else
                                    begin
                                        tbl_next.colour_base =
                                            {ctrl_next[CR_COLOUR], 6'b0} & sm;
                                        tbl_next.pattern_base =
                                            {ctrl_next[CR_PATTERN][2:0], 11'b0} & sm;
                                    end
                                    tbl_next.mode = {ctrl_next[CR_MODE1][3],
                                                     rev_a_reg & ctrl_next[CR_MODE0][1],
                                                     ctrl_next[CR_MODE1][4]};
                                end
                                CR_MODE1:
                                begin
                                    int_next = status_reg[StatVblankBit]
                                             & ctrl_next[CR_MODE1][R1IntEnableBit];
                                    tbl_next.mode = {ctrl_next[CR_MODE1][3],
                                                     rev_a_reg & ctrl_next[CR_MODE0][1],
                                                     ctrl_next[CR_MODE1][4]};
                                end
                                CR_NAME:
                                    tbl_next.name_base = {wr_val[3:0], 10'b0} & sm;
                                CR_COLOUR:
                                begin
                                    if (bitmap)
                                    begin
                                        tbl_next.colour_base  = {wr_val[7], 13'b0} & sm;
                                        tbl_next.colour_mask  = cmask;
                                        tbl_next.pattern_mask = pmask;
                                    end
                                    else
                                        tbl_next.colour_base = {wr_val, 6'b0} & sm;
                                end
                                CR_PATTERN:
                                begin
                                    if (bitmap)
                                    begin
                                        tbl_next.pattern_base = {wr_val[2], 13'b0} & sm;
                                        tbl_next.colour_mask  = cmask;
                                        tbl_next.pattern_mask = pmask;
                                    end
                                    else
                                        tbl_next.pattern_base = {wr_val[2:0], 11'b0} & sm;
                                end
                                CR_SATTR:
                                    tbl_next.sattr_base = {wr_val[6:0], 7'b0} & sm;
                                CR_SPAT:
                                    tbl_next.spat_base = {wr_val[2:0], 11'b0} & sm;
                                default:
                                    tbl_next = tbl_reg;
                            endcase
                        end
                        else if (!data[6])
                        begin
                            // read-ahead after the address load
                            mem_req.re   = 1'b1;
                            mem_req.addr = addr_hi[VramAw-1:0];
                            fetch_next   = 1'b1;
                            addr_next    = (addr_hi + 1'b1) & sm;
                        end
                    end
                end
                ACT_STAT_READ:
                begin
                    rd          = status_reg;
                    status_next = {3'b000, FifthSpriteIdle};
                    int_next    = status_next[StatVblankBit]
                                & ctrl_reg[CR_MODE1][R1IntEnableBit];
                    pend_next   = 1'b0;
                end
                ACT_LINE_TICK:
                begin
                    if (line_inc == top_border + ActiveLines)
                    begin
                        status_next[StatVblankBit] = 1'b1;
                        int_next = ctrl_reg[CR_MODE1][R1IntEnableBit];
                    end
                    if (line_inc >= frame_lines)
                        line_next = '0;
                    else
                        line_next = line_inc[8:0];
                end
                default:
                    rd = 8'h00;
            endcase
        end
    end

    // control registers only change on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                ctrl_reg[i] <= 8'h00;
        end
        else if (accept && action == ACT_CTRL_WRITE && pend_reg && data[7])
        begin
            for (int i = 0; i < 8; i++)
                ctrl_reg[i] <= ctrl_next[i];
        end
    end

    // port state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            addr_reg   <= '0;
            ra_reg     <= 8'h00;
            pend_reg   <= 1'b0;
            int_reg    <= 1'b0;
            line_reg   <= '0;
            fetch_reg  <= 1'b0;
            tbl_reg    <= '{mode: 3'b000, name_base: '0, colour_base: '0,
                            pattern_base: '0, sattr_base: '0, spat_base: '0,
                            colour_mask: 14'h3fff, pattern_mask: 14'h3fff};
        end
        else
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            ra_reg     <= ra_next;
            pend_reg   <= pend_next;
            int_reg    <= int_next;
            line_reg   <= line_next;
            fetch_reg  <= fetch_next;
            tbl_reg    <= tbl_next;
        end
    end

    // result item reflects the state after the action
    assign result.read_data = rd;
    assign result.int_line  = int_next;
    assign result.tbl       = tbl_next;

    // a pending fetch always comes from the item accepted just before
    `VDP_ASSERT(a_fetch_follows_accept, clk, rst_n,
        fetch_reg |-> $past(accept), "read-ahead fetch without an accepted item")

    // a status read leaves the idle fifth-sprite value behind
    `VDP_ASSERT(a_status_reload, clk, rst_n,
        (accept && action == ACT_STAT_READ) |=> (status_reg == {3'b000, FifthSpriteIdle}),
        "status byte not reloaded after status read")

endmodule

### src/vdp_out_buf.sv
// ----------------------------------------------------------------------------
// vdp_out_buf
// Output register with a skid entry for result items
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vdp_pkg::result_t  push_item,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output vdp_pkg::result_t  out_item
);
    import vdp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    // move items towards the output, park one when stalled
    always_comb
    begin
        pop             = main_valid_reg && !out_stall;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_item;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    // the skid entry is only ever behind a waiting output item
    `VDP_ASSERT_ALWAYS(a_skid_behind_main, clk,
        skid_valid_reg |-> main_valid_reg, "skid entry held with empty output register")

    // nothing may be pushed while the skid entry is occupied
    `VDP_ASSERT(a_no_push_when_full, clk, rst_n,
        skid_valid_reg |-> !push, "item pushed into a full output buffer")

endmodule

### src/vdp_cpu_port_interface.sv
// ----------------------------------------------------------------------------
// vdp_cpu_port_interface
// Processor port of a video display processor: memory, registers, status
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one processor access per item:
// action selects data write, data read, control write, status read or a line
// tick, data is the byte written. Each item gives exactly one result item on
// the output channel (out_valid / out_stall): the read byte and the register
// view after the access.
// Throughput is one item per cycle while in_stall is low. Each result is
// registered in the output register. Memory reads go through the single port
// video memory with a registered read; the fetched byte is forwarded to the
// read-ahead so a read may follow in the next cycle.
// The output has a register and a skid entry: while out_stall holds, one more
// item is taken, then in_stall rises until the output drains.
// After reset the video memory is swept to zero, one byte a cycle, over all
// 16384 bytes; in_stall stays high during the sweep. Configuration writes
// (cfg_valid / cfg_ready) are taken at any time; cfg_ready is always high.
// ----------------------------------------------------------------------------
module vdp_cpu_port_interface (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        int_line,
    output logic [2:0]  display_mode,
    output logic [13:0] name_base,
    output logic [13:0] colour_base,
    output logic [13:0] pattern_base,
    output logic [13:0] sprite_attr_base,
    output logic [13:0] sprite_pattern_base,
    output logic [13:0] colour_mask,
    output logic [13:0] pattern_mask,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    import vdp_pkg::*;

    logic     accept;
    logic     mem_busy;
    logic     buf_full;
    logic [7:0] mem_rdata;
    mem_req_t mem_req;
    result_t  result;
    result_t  out_item;

    // input handshake
    assign in_stall  = mem_busy || buf_full;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    vdp_vram u_vram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    vdp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .data      (data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_rdata (mem_rdata),
        .mem_req   (mem_req),
        .result    (result)
    );

    vdp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // result fields
    assign read_data           = out_item.read_data;
    assign int_line            = out_item.int_line;
    assign display_mode        = out_item.tbl.mode;
    assign name_base           = out_item.tbl.name_base;
    assign colour_base         = out_item.tbl.colour_base;
    assign pattern_base        = out_item.tbl.pattern_base;
    assign sprite_attr_base    = out_item.tbl.sattr_base;
    assign sprite_pattern_base = out_item.tbl.spat_base;
    assign colour_mask         = out_item.tbl.colour_mask;
    assign pattern_mask        = out_item.tbl.pattern_mask;

endmodule

### dv/vdp_cpu_port_interface_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vdp_cpu_port_interface_tb
// Self-checking bench for the processor port of the video display processor
// ----------------------------------------------------------------------------
// A table of directed port accesses comes first, then random access
// sequences over several configuration settings. These include address
// setups with data bursts, register writes, line tick runs, status reads and
// broken or undefined accesses. A behavioural copy of the port predicts the
// result of every item. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module vdp_cpu_port_interface_tb;

    import vdp_pkg::*;

    localparam int CycleLimit = 400000;

    // action codes the block ignores
    localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    // second control byte: register write, or write setup when bit 7 is clear
    localparam logic [7:0] CTRL_REG_WRITE   = 8'h80;
    localparam logic [7:0] CTRL_WRITE_SETUP = 8'h40;

    typedef struct {
        logic [7:0]  rd;
        logic        irq;
        logic [2:0]  mode;
        logic [13:0] nm;
        logic [13:0] col;
        logic [13:0] pat;
        logic [13:0] sa;
        logic [13:0] sp;
        logic [13:0] cmask;
        logic [13:0] pmask;
    } port_view_t;

    typedef struct {
        logic [2:0] act;
        logic [7:0] val;
        bit         known;
        logic [7:0] rd;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        int_line;
    logic [2:0]  display_mode;
    logic [13:0] name_base;
    logic [13:0] colour_base;
    logic [13:0] pattern_base;
    logic [13:0] sprite_attr_base;
    logic [13:0] sprite_pattern_base;
    logic [13:0] colour_mask;
    logic [13:0] pattern_mask;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;

    // behavioural copy of the port state
    logic [7:0]  vram [VramDepth];
    logic [7:0]  creg [8];
    logic [7:0]  stat_q;
    logic [13:0] vaddr;
    logic [7:0]  ahead;
    logic        hi_due;
    logic        irq_q;
    int          line_cnt;
    logic [2:0]  mode_q;
    logic [13:0] nm_base, col_base, pat_base, sa_base, sp_base, col_mask, pat_mask;
    logic [1:0]  size_sel;
    logic        fam_sel, rev_sel, pal_sel;

    port_view_t  views_due [$];
    port_view_t  seen_want;
    dir_row_t    steps [25];

    bit          idle_on = 1'b1;
    int          n_fail = 0;
    int          n_taken = 0;
    int          n_checked = 0;
    int          n_vblank = 0;
    int          n_irq = 0;
    int          cycles = 0;

    vdp_cpu_port_interface dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .action              (action),
        .data                (data),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .read_data           (read_data),
        .int_line            (int_line),
        .display_mode        (display_mode),
        .name_base           (name_base),
        .colour_base         (colour_base),
        .pattern_base        (pattern_base),
        .sprite_attr_base    (sprite_attr_base),
        .sprite_pattern_base (sprite_pattern_base),
        .colour_mask         (colour_mask),
        .pattern_mask        (pattern_mask),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("%0t: run limit reached with %0d results outstanding",
                     $time, views_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // port model
    // ------------------------------------------------------------------

    // address mask of the memory size in use, capped at the fitted depth
    function automatic logic [13:0] span_mask();
        int sz;
        case (size_sel)
            2'd0:    sz = 4096;
            2'd1:    sz = 8192;
            default: sz = 16384;
        endcase
        if (sz > VramDepth)
            sz = VramDepth;
        return 14'(sz - 1);
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < VramDepth; i++)
            vram[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            creg[i] = 8'h00;
        stat_q   = 8'h00;
        vaddr    = '0;
        ahead    = 8'h00;
        hi_due   = 1'b0;
        irq_q    = 1'b0;
        line_cnt = 0;
        mode_q   = 3'd0;
        nm_base  = '0;
        col_base = '0;
        pat_base = '0;
        sa_base  = '0;
        sp_base  = '0;
        col_mask = 14'h3fff;
        pat_mask = 14'h3fff;
        size_sel = 2'd2;
        fam_sel  = 1'b0;
        rev_sel  = 1'b1;
        pal_sel  = 1'b0;
    endfunction

    // fetch into the read-ahead and step the address
    function automatic void fetch_ahead();
        logic [13:0] m;
        m     = span_mask();
        ahead = vram[vaddr & m];
        vaddr = ((vaddr & m) + 14'd1) & m;
    endfunction

    function automatic void eval_irq();
        irq_q = stat_q[StatVblankBit] & creg[CR_MODE1][R1IntEnableBit];
    endfunction

    // bitmap mode index masks
    function automatic void bitmap_masks();
        logic [9:0] cm;
        cm       = {creg[CR_COLOUR][6:0], 3'b111};
        col_mask = 14'(cm);
        pat_mask = {4'b0000, creg[CR_PATTERN][1:0], fam_sel ? cm[7:0] : 8'hff};
    endfunction

    function automatic void eval_mode();
        mode_q = {creg[CR_MODE1][3], rev_sel & creg[CR_MODE0][1], creg[CR_MODE1][4]};
    endfunction

    function automatic void write_creg(input logic [2:0] r, input logic [7:0] raw);
        logic [7:0]  v;
        logic [13:0] m;
        logic        bitmap;
        m       = span_mask();
        v       = raw & RegWriteMask[r];
        creg[r] = v;
        bitmap  = creg[CR_MODE0][1];
        case (r)
            CR_MODE0:
            begin
                if (bitmap)
                begin
                    col_base = {creg[CR_COLOUR][7], 13'h0} & m;
                    pat_base = {creg[CR_PATTERN][2], 13'h0} & m;
                    bitmap_masks();
                end
                else
                begin
                    col_base = (14'(creg[CR_COLOUR]) << 6) & m;
                    pat_base = (14'(creg[CR_PATTERN]) << 11) & m;
                end
                eval_mode();
            end
            CR_MODE1:
            begin
                eval_irq();
                eval_mode();
            end
            CR_NAME:
                nm_base = (14'(v) << 10) & m;
            CR_COLOUR:
            begin
                if (bitmap)
                begin
                    col_base = {v[7], 13'h0} & m;
                    bitmap_masks();
                end
                else
                    col_base = (14'(v) << 6) & m;
            end
            CR_PATTERN:
            begin
                if (bitmap)
                begin
                    pat_base = {v[2], 13'h0} & m;
                    bitmap_masks();
                end
                else
                    pat_base = (14'(v) << 11) & m;
            end
            CR_SATTR:
                sa_base = (14'(v) << 7) & m;
            CR_SPAT:
                sp_base = (14'(v) << 11) & m;
            default: ;
        endcase
    endfunction

    // apply one processor access and return the port view after it
    function automatic port_view_t apply_access(input logic [2:0] act, input logic [7:0] val);
        port_view_t  v;
        logic [13:0] m;
        int          nxt;
        m    = span_mask();
        v.rd = 8'h00;
        case (act)
            ACT_DATA_WRITE:
            begin
                vram[vaddr & m] = val;
                vaddr  = ((vaddr & m) + 14'd1) & m;
                ahead  = val;
                hi_due = 1'b0;
            end
            ACT_DATA_READ:
            begin
                v.rd = ahead;
                fetch_ahead();
                hi_due = 1'b0;
            end
            ACT_CTRL_WRITE:
            begin
                if (hi_due)
                begin
                    vaddr = {val[5:0], vaddr[7:0]} & m;
                    if (val[7])
                        write_creg(val[2:0], vaddr[7:0]);
                    else if (!val[6])
                        fetch_ahead();
                    hi_due = 1'b0;
                end
                else
                begin
                    vaddr  = {vaddr[13:8], val} & m;
                    hi_due = 1'b1;
                end
            end
            ACT_STAT_READ:
            begin
                v.rd   = stat_q;
                stat_q = {3'b000, FifthSpriteIdle};
                eval_irq();
                hi_due = 1'b0;
            end
            ACT_LINE_TICK:
            begin
                nxt = line_cnt + 1;
                if (nxt == int'(pal_sel ? TopBorderPal : TopBorderNtsc) + int'(ActiveLines))
                begin
                    stat_q[StatVblankBit] = 1'b1;
                    eval_irq();
                    n_vblank++;
                end
                if (nxt >= int'(pal_sel ? LinesPal : LinesNtsc))
                    nxt = 0;
                line_cnt = nxt;
            end
            default: ;
        endcase
        v.irq   = irq_q;
        v.mode  = mode_q;
        v.nm    = nm_base;
        v.col   = col_base;
        v.pat   = pat_base;
        v.sa    = sa_base;
        v.sp    = sp_base;
        v.cmask = col_mask;
        v.pmask = pat_mask;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one item on the input channel, with an occasional gap before it
    task automatic send_item(input logic [2:0] act, input logic [7:0] val,
                             input bit known = 1'b0, input logic [7:0] known_rd = 8'h00);
        port_view_t v;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        data     <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = apply_access(act, val);
        if (known)
            v.rd = known_rd;
        if (v.irq)
            n_irq++;
        views_due.push_back(v);
        if (act < ACT_UNDEF_LO)
            n_taken++;
    endtask

    // let every outstanding result drain
    task automatic settle();
        in_valid <= 1'b0;
        while (views_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_VRAM_SIZE: size_sel = val;
            CFG_FAMILY:    fam_sel  = val[0];
            CFG_REVISION:  rev_sel  = val[0];
            CFG_PAL:       pal_sel  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] sel, input logic fam, input logic rev,
                              input logic pal);
        settle();
        write_cfg(CFG_VRAM_SIZE, sel);
        write_cfg(CFG_FAMILY, {1'b0, fam});
        write_cfg(CFG_REVISION, {1'b0, rev});
        write_cfg(CFG_PAL, {1'b0, pal});
        cfg_valid <= 1'b0;
    endtask

    // random access sequences, mostly well formed
    task automatic run_random(input int goal);
        int         start;
        int         kind;
        int         k;
        logic [7:0] hi;
        logic [2:0] r;
        start = n_taken;
        while (n_taken - start < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                // address setup, then a burst of data accesses
                hi = {2'b00, 6'($urandom)} | ($urandom_range(0, 1) ? CTRL_WRITE_SETUP : 8'h00);
                send_item(ACT_CTRL_WRITE, 8'($urandom));
                send_item(ACT_CTRL_WRITE, hi);
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_item(hi[6] ? ACT_DATA_READ : ACT_DATA_WRITE, 8'($urandom));
                    else
                        send_item(hi[6] ? ACT_DATA_WRITE : ACT_DATA_READ, 8'($urandom));
                end
            end
            else if (kind < 35)
            begin
                // register write, interrupt enable register favoured
                r = ($urandom_range(0, 3) == 0) ? CR_MODE1 : 3'($urandom);
                send_item(ACT_CTRL_WRITE, 8'($urandom));
                send_item(ACT_CTRL_WRITE, CTRL_REG_WRITE | {1'b0, 4'($urandom), r});
            end
            else if (kind < 60)
            begin
                // run of scanlines
                repeat ($urandom_range(1, 40))
                    send_item(ACT_LINE_TICK, 8'($urandom));
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 2))
                    send_item(ACT_STAT_READ, 8'($urandom));
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 1) ? ACT_DATA_WRITE : ACT_DATA_READ,
                              8'($urandom));
            end
            else if (kind < 90)
            begin
                // first control byte broken off by another access
                send_item(ACT_CTRL_WRITE, 8'($urandom));
                k = $urandom_range(0, 2);
                send_item(k == 0 ? ACT_DATA_WRITE : (k == 1 ? ACT_DATA_READ : ACT_STAT_READ),
                          8'($urandom));
            end
            else if (kind < 95)
                send_item(3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI)), 8'($urandom));
            else
                send_item(3'($urandom), 8'($urandom));
        end
    endtask

    // output stall in bursts, with long quiet stretches now and then
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
            if (idle_on)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void cmp(input string field, input logic [13:0] want,
                                input logic [13:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (views_due.size() == 0)
            begin
                $display("%0t: result item with nothing expected, read_data %0h",
                         $time, read_data);
                n_fail++;
            end
            else
            begin
                seen_want = views_due.pop_front();
                n_checked++;
                cmp("read_data", 14'(seen_want.rd), 14'(read_data));
                cmp("int_line", 14'(seen_want.irq), 14'(int_line));
                cmp("display_mode", 14'(seen_want.mode), 14'(display_mode));
                cmp("name_base", seen_want.nm, name_base);
                cmp("colour_base", seen_want.col, colour_base);
                cmp("pattern_base", seen_want.pat, pattern_base);
                cmp("sprite_attr_base", seen_want.sa, sprite_attr_base);
                cmp("sprite_pattern_base", seen_want.sp, sprite_pattern_base);
                cmp("colour_mask", seen_want.cmask, colour_mask);
                cmp("pattern_mask", seen_want.pmask, pattern_mask);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_DATA_WRITE;
        data      = 8'h00;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VRAM_SIZE;
        cfg_data  = 2'd0;
        reset_model();

        // directed accesses from reset, read bytes typed in where obvious
        steps = '{
            '{ACT_STAT_READ,  8'h00, 1'b1, 8'h00},  // status after reset
            '{ACT_STAT_READ,  8'hff, 1'b1, 8'h1f},  // reloaded with idle sprite number
            '{ACT_DATA_READ,  8'h00, 1'b1, 8'h00},  // read-ahead after reset
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'h7f, 1'b0, 8'h00},  // write setup at top of memory
            '{ACT_DATA_WRITE, 8'ha5, 1'b0, 8'h00},  // address wraps to zero
            '{ACT_DATA_READ,  8'h00, 1'b1, 8'ha5},  // written byte is the read-ahead
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'h3f, 1'b0, 8'h00},  // read setup at top of memory
            '{ACT_DATA_READ,  8'h00, 1'b1, 8'ha5},
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, CTRL_REG_WRITE | 8'(CR_MODE0), 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, CTRL_REG_WRITE | 8'(CR_MODE1), 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, CTRL_REG_WRITE | 8'(CR_COLOUR), 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'hff, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, CTRL_REG_WRITE | 8'(CR_PATTERN), 1'b0, 8'h00},
            '{ACT_UNDEF_LO,   8'hff, 1'b1, 8'h00},  // undefined actions read zero
            '{ACT_UNDEF_HI,   8'h00, 1'b1, 8'h00},
            '{ACT_LINE_TICK,  8'h00, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'h00, 1'b0, 8'h00},  // first byte only
            '{ACT_STAT_READ,  8'h00, 1'b1, 8'h1f},  // drops the pending byte
            '{ACT_CTRL_WRITE, 8'h00, 1'b0, 8'h00},
            '{ACT_CTRL_WRITE, 8'h00, 1'b0, 8'h00}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(2'd2, 1'b0, 1'b1, 1'b0);
        foreach (steps[i])
            send_item(steps[i].act, steps[i].val, steps[i].known, steps[i].rd);
        run_random(300);

        // smallest memory, other family and revision, long frame
        set_config(2'd0, 1'b1, 1'b0, 1'b1);
        run_random(330);
        // leave the long frame past the end of the short one
        while (line_cnt < 270 || line_cnt > 310)
            send_item(ACT_LINE_TICK, 8'($urandom));

        set_config(2'd1, 1'b1, 1'b1, 1'b0);
        run_random(330);

        // size select three
        set_config(2'd3, 1'b0, 1'b1, 1'b1);
        run_random(330);

        // closing stretch without idling
        idle_on = 1'b0;
        set_config(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        run_random(330);

        settle();
        repeat (12) @(posedge clk);

        $display("covered %0d port accesses and %0d checked results,", n_taken, n_checked);
        $display("with %0d vblank entries and %0d results with the interrupt raised",
                 n_vblank, n_irq);
        if (n_fail == 0 && views_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/vdp_pkg.sv
src/vdp_vram.sv
src/vdp_regs.sv
src/vdp_out_buf.sv
src/vdp_cpu_port_interface.sv
dv/vdp_cpu_port_interface_tb.sv
